// ===== design/mi3_pkg.sv =====
// shared types, widths and index tables for the 3x3 matrix inverse core
package mi3_pkg;

    // element format
    localparam int ELEM_W    = 16;
    localparam int FRAC_W    = 8;
    localparam int NUM_ELEM  = 9;

    // exact intermediate widths
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int COF_W     = 2 * ELEM_W + 1;
    localparam int TRI_W     = ELEM_W + COF_W;
    localparam int DET_W     = 3 * ELEM_W + 3;
    localparam int NUM_W     = COF_W + 2 * FRAC_W;
    localparam int REM_W     = ((NUM_W > DET_W) ? NUM_W : DET_W) + ELEM_W + 2;
    localparam int QUO_W     = ELEM_W + 1;

    // pipeline depth
    localparam int FRONT_STG = 4;
    localparam int LANE_STG  = ELEM_W + 3;
    localparam int PIPE_STG  = FRONT_STG + LANE_STG + 1;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [COF_W-1:0]  t_cof;
    typedef logic signed [DET_W-1:0]  t_det;

    // cofactor operand indexes: adj = m[a]*m[b] - m[c]*m[d]
    localparam int COF_IDX [NUM_ELEM][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    // first column of the adjugate, paired with row 0 for the determinant
    localparam int DET_IDX [3] = '{0, 3, 6};

    typedef struct packed {
        t_elem in_r0c0;
        t_elem in_r0c1;
        t_elem in_r0c2;
        t_elem in_r1c0;
        t_elem in_r1c1;
        t_elem in_r1c2;
        t_elem in_r2c0;
        t_elem in_r2c1;
        t_elem in_r2c2;
    } t_in;

    typedef struct packed {
        t_elem out_r0c0;
        t_elem out_r0c1;
        t_elem out_r0c2;
        t_elem out_r1c0;
        t_elem out_r1c1;
        t_elem out_r1c2;
        t_elem out_r2c0;
        t_elem out_r2c1;
        t_elem out_r2c2;
        logic  singular;
        logic  saturated;
    } t_out;

endpackage

// ===== design/mi3_front.sv =====
// cofactor and determinant pipeline: four registered stages
module mi3_front (
    input  logic                                  i_clk,
    input  logic [mi3_pkg::FRONT_STG-1:0]         i_en,
    input  mi3_pkg::t_in                          i_mat,
    output mi3_pkg::t_cof                         o_adj [mi3_pkg::NUM_ELEM],
    output mi3_pkg::t_det                         o_det
);

    mi3_pkg::t_elem m [mi3_pkg::NUM_ELEM];

    logic signed [mi3_pkg::PROD_W-1:0] r_pa [mi3_pkg::NUM_ELEM];
    logic signed [mi3_pkg::PROD_W-1:0] r_pb [mi3_pkg::NUM_ELEM];
    mi3_pkg::t_elem r_row_a [3];
    mi3_pkg::t_elem r_row_b [3];
    mi3_pkg::t_cof  r_cof_b [mi3_pkg::NUM_ELEM];
    mi3_pkg::t_cof  r_cof_c [mi3_pkg::NUM_ELEM];
    mi3_pkg::t_cof  r_cof_d [mi3_pkg::NUM_ELEM];
    logic signed [mi3_pkg::TRI_W-1:0] r_tri [3];
    mi3_pkg::t_det  r_det;

    // unpack the item
    assign m[0] = i_mat.in_r0c0;
    assign m[1] = i_mat.in_r0c1;
    assign m[2] = i_mat.in_r0c2;
    assign m[3] = i_mat.in_r1c0;
    assign m[4] = i_mat.in_r1c1;
    assign m[5] = i_mat.in_r1c2;
    assign m[6] = i_mat.in_r2c0;
    assign m[7] = i_mat.in_r2c1;
    assign m[8] = i_mat.in_r2c2;

    genvar gi;
    generate
        for (gi = 0; gi < mi3_pkg::NUM_ELEM; gi++) begin : g_cof
            // pair products
            always_ff @(posedge i_clk) begin
                if (i_en[0]) begin
                    r_pa[gi] <= m[mi3_pkg::COF_IDX[gi][0]] * m[mi3_pkg::COF_IDX[gi][1]];
                    r_pb[gi] <= m[mi3_pkg::COF_IDX[gi][2]] * m[mi3_pkg::COF_IDX[gi][3]];
                end
            end
            // exact difference
            always_ff @(posedge i_clk) begin
                if (i_en[1]) begin
                    r_cof_b[gi] <= mi3_pkg::COF_W'(r_pa[gi]) - mi3_pkg::COF_W'(r_pb[gi]);
                end
            end
            // carry cofactors alongside the determinant
            always_ff @(posedge i_clk) begin
                if (i_en[2]) begin
                    r_cof_c[gi] <= r_cof_b[gi];
                end
                if (i_en[3]) begin
                    r_cof_d[gi] <= r_cof_c[gi];
                end
            end
            assign o_adj[gi] = r_cof_d[gi];
        end

        for (gi = 0; gi < 3; gi++) begin : g_row
            // row 0 travels to the determinant products
            always_ff @(posedge i_clk) begin
                if (i_en[0]) begin
                    r_row_a[gi] <= m[gi];
                end
                if (i_en[1]) begin
                    r_row_b[gi] <= r_row_a[gi];
                end
            end
            // laplace expansion along row 0
            always_ff @(posedge i_clk) begin
                if (i_en[2]) begin
                    r_tri[gi] <= mi3_pkg::TRI_W'(r_row_b[gi])
                               * mi3_pkg::TRI_W'(r_cof_b[mi3_pkg::DET_IDX[gi]]);
                end
            end
        end
    endgenerate

    // determinant sum
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_det <= mi3_pkg::DET_W'(r_tri[0]) + mi3_pkg::DET_W'(r_tri[1])
                   + mi3_pkg::DET_W'(r_tri[2]);
        end
    end

    assign o_det = r_det;

endmodule

// ===== design/mi3_lane.sv =====
// one output element: pipelined restoring divide with saturation
module mi3_lane (
    input  logic                              i_clk,
    input  logic [mi3_pkg::LANE_STG-1:0]      i_en,
    input  mi3_pkg::t_cof                     i_adj,
    input  mi3_pkg::t_det                     i_det,
    output mi3_pkg::t_elem                    o_elem,
    output logic                              o_sat
);

    localparam int NSTEP = mi3_pkg::QUO_W;
    localparam int W     = mi3_pkg::ELEM_W;

    logic [mi3_pkg::REM_W-1:0] r_rem [NSTEP+1];
    logic [mi3_pkg::DET_W-1:0] r_dm  [NSTEP+1];
    logic [mi3_pkg::QUO_W-1:0] r_q   [NSTEP+1];
    logic                      r_neg [NSTEP+1];
    logic                      r_ovf [NSTEP+1];
    mi3_pkg::t_elem            r_elem;
    logic                      r_sat;

    logic [mi3_pkg::COF_W-1:0] adj_mag;
    logic [mi3_pkg::DET_W-1:0] det_mag;

    // magnitudes
    always_comb begin
        adj_mag = i_adj[mi3_pkg::COF_W-1] ? mi3_pkg::COF_W'(-i_adj) : i_adj;
        det_mag = i_det[mi3_pkg::DET_W-1] ? mi3_pkg::DET_W'(-i_det) : i_det;
    end

    // prep stage
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= mi3_pkg::REM_W'(adj_mag) << (2 * mi3_pkg::FRAC_W);
            r_dm[0]  <= det_mag;
            r_neg[0] <= i_adj[mi3_pkg::COF_W-1] ^ i_det[mi3_pkg::DET_W-1];
            r_q[0]   <= '0;
            r_ovf[0] <= 1'b0;
        end
    end

    genvar gj;
    generate
        for (gj = 1; gj <= NSTEP; gj++) begin : g_step
            localparam int K = NSTEP - gj;
            logic [mi3_pkg::REM_W-1:0] dsh;
            logic                      take;
            logic                      ovf;
            assign dsh  = mi3_pkg::REM_W'(r_dm[gj-1]) << K;
            assign take = (r_rem[gj-1] >= dsh);
            // quotient too large for the step chain when first step is reached
            if (gj == 1) begin : g_ovf
                assign ovf = (r_rem[0] >= (mi3_pkg::REM_W'(r_dm[0]) << NSTEP));
            end else begin : g_novf
                assign ovf = r_ovf[gj-1];
            end
            // one quotient bit a stage
            always_ff @(posedge i_clk) begin
                if (i_en[gj]) begin
                    r_rem[gj] <= take ? (r_rem[gj-1] - dsh) : r_rem[gj-1];
                    r_q[gj]   <= r_q[gj-1] | (take ? (mi3_pkg::QUO_W'(1) << K) : '0);
                    r_dm[gj]  <= r_dm[gj-1];
                    r_neg[gj] <= r_neg[gj-1];
                    r_ovf[gj] <= ovf;
                end
            end
        end
    endgenerate

    // sign and saturation
    logic [mi3_pkg::QUO_W-1:0] q;
    logic                      neg;
    always_comb begin
        q   = r_q[NSTEP];
        neg = r_neg[NSTEP] && ((q != '0) || r_ovf[NSTEP]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[NSTEP+1]) begin
            if (neg) begin
                if (r_ovf[NSTEP] || (q > (mi3_pkg::QUO_W'(1) << (W - 1)))) begin
                    r_elem <= {1'b1, {(W-1){1'b0}}};
                    r_sat  <= 1'b1;
                end else begin
                    r_elem <= W'(-q);
                    r_sat  <= 1'b0;
                end
            end else begin
                if (r_ovf[NSTEP] || (q > ((mi3_pkg::QUO_W'(1) << (W - 1)) - 1'b1))) begin
                    r_elem <= {1'b0, {(W-1){1'b1}}};
                    r_sat  <= 1'b1;
                end else begin
                    r_elem <= W'(q);
                    r_sat  <= 1'b0;
                end
            end
        end
    end

    assign o_elem = r_elem;
    assign o_sat  = r_sat;

endmodule

// ===== design/matrix3x3_inverse_core.sv =====
// top level: 3x3 matrix inverse, nine divide lanes and a merge stage
//
// input channel: i_valid / o_stall carry one matrix (i_data) per item.
// output channel: o_valid / i_stall carry the inverse (o_data) with the
// singular and saturated flags.
// an item is taken at a clock edge with valid high and stall low.
// from acceptance to o_valid an item passes four cofactor/determinant
// stages, one prep stage, one divide stage per quotient bit (ELEM_W + 1),
// a saturate stage and the merge register.
// throughput: one matrix per cycle unless the receiver stalls; every
// stage holds its own item. when the receiver stalls, stages fill from
// the output backward; an empty stage still takes the item ahead of it,
// so the input is stalled only once the whole pipeline is full.
// reset (synchronous, active low) drops every stage valid; no item is lost
// after reset since none is held.
// a zero determinant gives all zero elements with singular set.
module matrix3x3_inverse_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  mi3_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output mi3_pkg::t_out o_data
);

    localparam int NS = mi3_pkg::PIPE_STG;
    localparam int FS = mi3_pkg::FRONT_STG;
    localparam int LS = mi3_pkg::LANE_STG;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] rdy;

    mi3_pkg::t_cof  adj [mi3_pkg::NUM_ELEM];
    mi3_pkg::t_det  det;
    mi3_pkg::t_elem elem [mi3_pkg::NUM_ELEM];
    logic [mi3_pkg::NUM_ELEM-1:0] sat;
    logic [LS-1:0]  r_sing;
    mi3_pkg::t_out  r_out;

    // stage ready chain from the output back
    always_comb begin
        rdy[NS-1] = !r_vld[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign o_stall = !rdy[0];

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    mi3_front u_front (
        .i_clk (i_clk),
        .i_en  (rdy[FS-1:0]),
        .i_mat (i_data),
        .o_adj (adj),
        .o_det (det)
    );

    genvar gi;
    generate
        for (gi = 0; gi < mi3_pkg::NUM_ELEM; gi++) begin : g_lane
            mi3_lane u_lane (
                .i_clk  (i_clk),
                .i_en   (rdy[FS+LS-1:FS]),
                .i_adj  (adj[gi]),
                .i_det  (det),
                .o_elem (elem[gi]),
                .o_sat  (sat[gi])
            );
        end
    endgenerate

    // singular flag travels beside the lanes
    always_ff @(posedge i_clk) begin
        if (rdy[FS]) begin
            r_sing[0] <= (det == '0);
        end
        for (int s = 1; s < LS; s++) begin
            if (rdy[FS+s]) begin
                r_sing[s] <= r_sing[s-1];
            end
        end
    end

    // merge stage
    always_ff @(posedge i_clk) begin
        if (rdy[NS-1]) begin
            if (r_sing[LS-1]) begin
                // all elements zero, singular set, not saturated
                r_out <= {{(mi3_pkg::NUM_ELEM * mi3_pkg::ELEM_W){1'b0}}, 1'b1, 1'b0};
            end else begin
                r_out.out_r0c0  <= elem[0];
                r_out.out_r0c1  <= elem[1];
                r_out.out_r0c2  <= elem[2];
                r_out.out_r1c0  <= elem[3];
                r_out.out_r1c1  <= elem[4];
                r_out.out_r1c2  <= elem[5];
                r_out.out_r2c0  <= elem[6];
                r_out.out_r2c1  <= elem[7];
                r_out.out_r2c2  <= elem[8];
                r_out.singular  <= 1'b0;
                r_out.saturated <= |sat;
            end
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_data  = r_out;

endmodule

// ===== design/mi3_checker.sv =====
// port-level checks for the matrix inverse core, bound to the top level
module mi3_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          o_stall,
    input  mi3_pkg::t_in  i_data,
    input  logic          o_valid,
    input  logic          i_stall,
    input  mi3_pkg::t_out o_data
);

    // nothing comes out right after reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("o_valid high after reset");

    // a waiting result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    // a stalled input item holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_data))
        else $error("stalled input item changed");

    // with no result pending the input is never stalled
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output");

    // singular results are unsaturated, with the diagonal and r0c2 zero
    a_sing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.singular |->
            !o_data.saturated && o_data.out_r0c0 == '0 && o_data.out_r1c1 == '0
            && o_data.out_r2c2 == '0 && o_data.out_r0c2 == '0)
        else $error("singular result not cleared");

endmodule

bind matrix3x3_inverse_core mi3_checker u_mi3_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

// ===== bench/tb_top.sv =====
// testbench for the 3x3 matrix inverse core: directed and random matrices
`timescale 1ns / 1ps

module tb_top;

    localparam int LATENCY = mi3_pkg::ELEM_W + 8;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    mi3_pkg::t_in  i_data;
    logic o_valid;
    logic i_stall;
    mi3_pkg::t_out o_data;

    mi3_pkg::t_out inverse_q[$];
    int   n_errors;
    int   n_results;
    bit   hold_long;

    matrix3x3_inverse_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // exact inverse of one matrix, quotient truncated toward zero then clipped
    function automatic mi3_pkg::t_out predict_inverse(mi3_pkg::t_in m_in);
        logic signed [15:0]  m [9];
        logic signed [127:0] adj [9];
        logic signed [127:0] det, num, q, dmag, nmag;
        int idx [9][4];
        mi3_pkg::t_out r;
        logic [15:0] e [9];
        bit neg, sat;
        idx = '{'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
                '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
                '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}};
        m = '{m_in.in_r0c0, m_in.in_r0c1, m_in.in_r0c2,
              m_in.in_r1c0, m_in.in_r1c1, m_in.in_r1c2,
              m_in.in_r2c0, m_in.in_r2c1, m_in.in_r2c2};
        det = 128'sd0;
        det = det + 128'(m[0]) * 128'(m[4]) * 128'(m[8]);
        det = det + 128'(m[1]) * 128'(m[5]) * 128'(m[6]);
        det = det + 128'(m[2]) * 128'(m[3]) * 128'(m[7]);
        det = det - 128'(m[2]) * 128'(m[4]) * 128'(m[6]);
        det = det - 128'(m[1]) * 128'(m[3]) * 128'(m[8]);
        det = det - 128'(m[0]) * 128'(m[5]) * 128'(m[7]);
        r = '0;
        if (det == 0) begin
            r.singular = 1'b1;
            return r;
        end
        sat = 1'b0;
        dmag = (det < 0) ? -det : det;
        for (int i = 0; i < 9; i++) begin
            adj[i] = 128'(m[idx[i][0]]) * 128'(m[idx[i][1]])
                   - 128'(m[idx[i][2]]) * 128'(m[idx[i][3]]);
            num = adj[i] <<< (2 * mi3_pkg::FRAC_W);
            nmag = (num < 0) ? -num : num;
            q = nmag / dmag;
            neg = ((num < 0) != (det < 0)) && (q != 0);
            if (neg) begin
                if (q > 128'sd32768) begin
                    q = 128'sd32768;
                    sat = 1'b1;
                end
                q = -q;
            end else if (q > 128'sd32767) begin
                q = 128'sd32767;
                sat = 1'b1;
            end
            e[i] = q[15:0];
        end
        r.out_r0c0 = e[0]; r.out_r0c1 = e[1]; r.out_r0c2 = e[2];
        r.out_r1c0 = e[3]; r.out_r1c1 = e[4]; r.out_r1c2 = e[5];
        r.out_r2c0 = e[6]; r.out_r2c1 = e[7]; r.out_r2c2 = e[8];
        r.saturated = sat;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        n_errors++;
        $display("mismatch result %0d %s: got %0d want %0d", n_results, what, got, want);
    endtask

    // send one item after a random gap; valid stays up until the next gap
    task automatic send_matrix(mi3_pkg::t_in m);
        int gap;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= m;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        inverse_q.push_back(predict_inverse(m));
    endtask

    function automatic mi3_pkg::t_elem rand_elem();
        case ($urandom_range(0, 5))
            0: return mi3_pkg::t_elem'($urandom_range(0, 65535));
            1: return mi3_pkg::t_elem'($signed($urandom_range(0, 1023)) - 512);
            2: return mi3_pkg::t_elem'(-32768);
            3: return mi3_pkg::t_elem'(32767);
            default: return mi3_pkg::t_elem'($signed($urandom_range(0, 4095)) - 2048);
        endcase
    endfunction

    function automatic mi3_pkg::t_in rand_matrix();
        mi3_pkg::t_in m;
        m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
             rand_elem(), rand_elem(), rand_elem(), rand_elem()};
        // make some singular: copy a row
        if ($urandom_range(0, 9) == 0) begin
            m.in_r2c0 = m.in_r0c0; m.in_r2c1 = m.in_r0c1; m.in_r2c2 = m.in_r0c2;
        end
        return m;
    endfunction

    function automatic mi3_pkg::t_in diag(mi3_pkg::t_elem a, mi3_pkg::t_elem b,
                                          mi3_pkg::t_elem c);
        mi3_pkg::t_in m;
        m = '0;
        m.in_r0c0 = a; m.in_r1c1 = b; m.in_r2c2 = c;
        return m;
    endfunction

    // drop valid and wait for every expected result
    task automatic drain();
        i_valid <= 1'b0;
        while (inverse_q.size() != 0) @(posedge i_clk);
    endtask

    // directed: identity, extremes, singular, saturating, negative
    task automatic test_directed();
        mi3_pkg::t_in m;
        send_matrix(diag(16'sd256, 16'sd256, 16'sd256));
        send_matrix(diag(-16'sd256, 16'sd512, 16'sd128));
        send_matrix('0);
        send_matrix({9{16'sh7fff}});
        send_matrix({9{16'sh8000}});
        send_matrix(diag(16'sh8000, 16'sh8000, 16'sh8000));
        send_matrix(diag(16'sh7fff, 16'sh7fff, 16'sh7fff));
        send_matrix(diag(16'sd1, 16'sd1, 16'sd1));
        send_matrix(diag(-16'sd1, 16'sd1, -16'sd1));
        send_matrix(diag(16'sh8000, 16'sh7fff, 16'sd1));
        send_matrix({16'hffff, 16'h5555, 16'haaaa, 16'h0f0f, 16'hf0f0,
                     16'h1234, 16'hedcb, 16'h8001, 16'h7ffe});
        m = diag(16'sd256, 16'sd256, 16'sd256);
        m.in_r0c1 = 16'sd300; m.in_r1c2 = -16'sd700; m.in_r2c0 = 16'sd50;
        send_matrix(m);
        m.in_r1c0 = m.in_r0c0; m.in_r1c1 = m.in_r0c1; m.in_r1c2 = m.in_r0c2;
        send_matrix(m);
        drain();
    endtask

    // random matrices with random gaps
    task automatic test_random(int count);
        for (int k = 0; k < count; k++) send_matrix(rand_matrix());
    endtask

    // receiver holds off while sender keeps offering, then sender waits
    task automatic test_backpressure();
        hold_long = 1'b1;
        for (int k = 0; k < 60; k++) begin
            i_valid <= 1'b1;
            i_data  <= rand_matrix();
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
            inverse_q.push_back(predict_inverse(i_data));
        end
        drain();
    endtask

    // receiver stall: random per item, with a long hold on request
    initial begin
        i_stall <= 1'b1;
        @(posedge i_rst_n);
        forever begin
            if (hold_long) begin
                i_stall <= 1'b1;
                repeat (200) @(posedge i_clk);
                hold_long = 1'b0;
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            if ($urandom_range(0, 2) != 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (inverse_q.size() == 0) begin
                report_mismatch("unexpected", 1, 0);
            end else begin
                mi3_pkg::t_out w;
                w = inverse_q.pop_front();
                if (o_data.out_r0c0 !== w.out_r0c0) report_mismatch("r0c0", o_data.out_r0c0, w.out_r0c0);
                if (o_data.out_r0c1 !== w.out_r0c1) report_mismatch("r0c1", o_data.out_r0c1, w.out_r0c1);
                if (o_data.out_r0c2 !== w.out_r0c2) report_mismatch("r0c2", o_data.out_r0c2, w.out_r0c2);
                if (o_data.out_r1c0 !== w.out_r1c0) report_mismatch("r1c0", o_data.out_r1c0, w.out_r1c0);
                if (o_data.out_r1c1 !== w.out_r1c1) report_mismatch("r1c1", o_data.out_r1c1, w.out_r1c1);
                if (o_data.out_r1c2 !== w.out_r1c2) report_mismatch("r1c2", o_data.out_r1c2, w.out_r1c2);
                if (o_data.out_r2c0 !== w.out_r2c0) report_mismatch("r2c0", o_data.out_r2c0, w.out_r2c0);
                if (o_data.out_r2c1 !== w.out_r2c1) report_mismatch("r2c1", o_data.out_r2c1, w.out_r2c1);
                if (o_data.out_r2c2 !== w.out_r2c2) report_mismatch("r2c2", o_data.out_r2c2, w.out_r2c2);
                if (o_data.singular !== w.singular) report_mismatch("singular", o_data.singular, w.singular);
                if (o_data.saturated !== w.saturated) report_mismatch("saturated", o_data.saturated, w.saturated);
            end
            n_results++;
        end
    end

    // run limit
    initial begin
        #5ms;
        $display("tb_top: FAIL");
        $finish;
    end

    // main sequence
    initial begin
        n_errors  = 0;
        n_results = 0;
        hold_long = 1'b0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(300);
        test_backpressure();
        test_random(330);
        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_errors == 0 && inverse_q.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/mi3_pkg.sv
design/mi3_front.sv
design/mi3_lane.sv
design/matrix3x3_inverse_core.sv
design/mi3_checker.sv
bench/tb_top.sv
